// ===== rtl/tcfe_pkg.sv =====
package tcfe_pkg;

    localparam int FUNC_W     = 2;
    localparam int SITE_IDX_W = 10;
    localparam int CTX_W      = 3;
    localparam int N_CTX      = 8;
    localparam int DRAW_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 2;

    localparam logic [COUNT_W-1:0] SITE_COUNT_RESET = 11'd1024;
    localparam int MIN_SITES = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_RECOUNT = 2'd1,
        FUNC_JUMP    = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_MATCH  = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_RANK,
        ST_SCAN,
        ST_FETCH,
        ST_ADJUST,
        ST_DONE
    } state_t;

    typedef logic [N_CTX-1:0][COUNT_W-1:0] count_vec_t;

    typedef struct packed {
        logic             clear;
        logic             bump;
        logic             up;
        logic [CTX_W-1:0] idx;
    } count_cmd_t;

endpackage

// ===== rtl/triplet_context_flip_engine_unit.sv =====
// Triplet-context flip engine. Holds a sequence of up to MAX_SITES site bits in
// a single-port-write, single-port-read memory and eight context counters. A load
// or an unused function code is settled in the dispatch state. A recount or a jump
// reads the sequence one site per cycle through the memory read port, and all
// counter updates go through one shared increment/decrement unit, one update per
// cycle (up to six for a flip). The rank of a jump comes from one registered
// DRAW_W by COUNT_W multiply. After reset a clearing pass writes every site to
// zero, during which no item is taken; configuration writes are taken at any time.
// A result waits in an output register, so the next item may be accepted before
// the previous result is taken.
module triplet_context_flip_engine_unit #(
    parameter int MAX_SITES = 1024,
    parameter int DRAW_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tcfe_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tcfe_pkg::FUNC_W-1:0]       s_func,
    input  logic [tcfe_pkg::SITE_IDX_W-1:0]   s_site_index,
    input  logic                              s_site_value,
    input  logic [tcfe_pkg::CTX_W-1:0]        s_context_code,
    input  logic [tcfe_pkg::DRAW_W-1:0]       s_uniform_draw,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tcfe_pkg::STATUS_W-1:0]     m_status,
    output logic [tcfe_pkg::SITE_IDX_W-1:0]   m_flipped_position,
    output logic [tcfe_pkg::COUNT_W-1:0]      m_count_000,
    output logic [tcfe_pkg::COUNT_W-1:0]      m_count_001,
    output logic [tcfe_pkg::COUNT_W-1:0]      m_count_010,
    output logic [tcfe_pkg::COUNT_W-1:0]      m_count_011,
    output logic [tcfe_pkg::COUNT_W-1:0]      m_count_100,
    output logic [tcfe_pkg::COUNT_W-1:0]      m_count_101,
    output logic [tcfe_pkg::COUNT_W-1:0]      m_count_110,
    output logic [tcfe_pkg::COUNT_W-1:0]      m_count_111
);
    import tcfe_pkg::*;

    localparam int AW     = $clog2(MAX_SITES);
    localparam int NW     = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam int U_KEEP = (DRAW_BITS < DRAW_W) ? DRAW_BITS : DRAW_W;
    localparam int PROD_W = DRAW_W + COUNT_W;
    localparam logic [DRAW_W-1:0] U_MASK = {DRAW_W{1'b1}} >> (DRAW_W - U_KEEP);
    localparam logic [AW-1:0]     CLR_LAST = AW'(MAX_SITES - 1);
    localparam logic [2:0]        ADJ_LAST = 3'd5;

    // site memory
    logic          mem [MAX_SITES];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          mem_re;
    logic          rdata_reg;
    logic          rvalid_reg;

    // control and item registers
    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] site_count_reg;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [NW-1:0]      idx_reg, idx_next;
    logic               val_reg, val_next;
    logic [CTX_W-1:0]   ctx_reg, ctx_next;
    logic [DRAW_W-1:0]  u_reg, u_next;
    logic [COUNT_W-1:0] rank_reg, rank_next;
    logic [COUNT_W-1:0] seen_reg, seen_next;
    logic [NW-1:0]      rd_addr_reg, rd_addr_next;
    logic [NW-1:0]      da_reg, da_next;
    logic [2:0]         win_reg, win_next;
    logic [NW-1:0]      hit_reg, hit_next;
    logic               l2_reg, l2_next;
    logic               l1_reg, l1_next;
    logic               c_reg, c_next;
    logic               r1_reg, r1_next;
    logic               r2_reg, r2_next;
    logic               has_l2_reg, has_l2_next;
    logic               has_r2_reg, has_r2_next;
    logic [2:0]         step_reg, step_next;
    logic [AW-1:0]      clr_reg, clr_next;
    status_t            status_reg, status_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [NW-1:0]      m_pos_reg, m_pos_next;
    count_vec_t         m_counts_reg, m_counts_next;

    count_cmd_t         cnt_cmd;
    count_vec_t         counts;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      n_last;
    logic [PROD_W-1:0]  product;

    tcfe_counts u_counts (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cnt_cmd),
        .counts  (counts)
    );

    always_comb begin
        logic [NW-1:0] sc;
        sc = NW'(site_count_reg);
        if (sc < NW'(MIN_SITES)) begin
            n_eff = NW'(MIN_SITES);
        end else if (sc > NW'(MAX_SITES)) begin
            n_eff = NW'(MAX_SITES);
        end else begin
            n_eff = sc;
        end
    end

    assign n_last  = n_eff - 1'b1;
    assign product = PROD_W'(u_reg & U_MASK) * PROD_W'(counts[ctx_reg]);

    always_comb begin
        logic [CTX_W-1:0] scan_ctx;
        logic             nc;
        scan_ctx      = {win_reg[1], win_reg[0], rdata_reg};
        nc            = ~c_reg;
        state_next    = state_reg;
        func_next     = func_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        ctx_next      = ctx_reg;
        u_next        = u_reg;
        rank_next     = rank_reg;
        seen_next     = seen_reg;
        rd_addr_next  = rd_addr_reg;
        da_next       = da_reg;
        win_next      = win_reg;
        hit_next      = hit_reg;
        l2_next       = l2_reg;
        l1_next       = l1_reg;
        c_next        = c_reg;
        r1_next       = r1_reg;
        r2_next       = r2_reg;
        has_l2_next   = has_l2_reg;
        has_r2_next   = has_r2_reg;
        step_next     = step_reg;
        clr_next      = clr_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_pos_next    = m_pos_reg;
        m_counts_next = m_counts_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_reg;
        mem_wdata     = 1'b0;
        mem_re        = 1'b0;
        cnt_cmd       = '0;
        s_ready       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next   = s_func;
                    idx_next    = NW'(s_site_index);
                    val_next    = s_site_value;
                    ctx_next    = s_context_code;
                    u_next      = s_uniform_draw;
                    status_next = STATUS_OK;
                    hit_next    = '0;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                rd_addr_next = '0;
                da_next      = '0;
                seen_next    = '0;
                state_next   = ST_DONE;
                case (func_reg)
                    FUNC_LOAD: begin
                        if (idx_reg >= n_eff) begin
                            status_next = STATUS_BAD_INDEX;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg[AW-1:0];
                            mem_wdata = val_reg;
                        end
                    end
                    FUNC_RECOUNT: begin
                        cnt_cmd.clear = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    FUNC_JUMP: begin
                        if (counts[ctx_reg] == '0) begin
                            status_next = STATUS_NO_MATCH;
                        end else begin
                            state_next = ST_RANK;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RANK: begin
                rank_next  = COUNT_W'(product >> DRAW_BITS) + 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // keep one read in flight ahead of the site being judged
                if (rd_addr_reg < n_eff) begin
                    mem_re       = 1'b1;
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                if (rvalid_reg) begin
                    da_next  = da_reg + 1'b1;
                    win_next = {win_reg[1:0], rdata_reg};
                    if (da_reg >= NW'(2)) begin
                        if (func_reg == FUNC_RECOUNT) begin
                            cnt_cmd.bump = 1'b1;
                            cnt_cmd.up   = 1'b1;
                            cnt_cmd.idx  = scan_ctx;
                            if (da_reg == n_last) begin
                                state_next = ST_DONE;
                            end
                        end else if ((scan_ctx == ctx_reg) && (seen_reg + 1'b1 == rank_reg)) begin
                            hit_next    = da_reg - 1'b1;
                            l2_next     = win_reg[2];
                            l1_next     = win_reg[1];
                            c_next      = win_reg[0];
                            r1_next     = rdata_reg;
                            has_l2_next = da_reg > NW'(2);
                            state_next  = ST_FETCH;
                        end else begin
                            if (scan_ctx == ctx_reg) begin
                                seen_next = seen_reg + 1'b1;
                            end
                            if (da_reg == n_last) begin
                                status_next = STATUS_NO_MATCH;
                                state_next  = ST_DONE;
                            end
                        end
                    end
                end
            end
            ST_FETCH: begin
                // the read issued with the hit brings the site two to the right
                r2_next     = rdata_reg;
                has_r2_next = rvalid_reg;
                step_next   = '0;
                state_next  = ST_ADJUST;
            end
            ST_ADJUST: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    3'd0: begin
                        cnt_cmd.bump = has_l2_reg;
                        cnt_cmd.idx  = {l2_reg, l1_reg, c_reg};
                    end
                    3'd1: begin
                        cnt_cmd.bump = has_l2_reg;
                        cnt_cmd.up   = 1'b1;
                        cnt_cmd.idx  = {l2_reg, l1_reg, nc};
                    end
                    3'd2: begin
                        cnt_cmd.bump = 1'b1;
                        cnt_cmd.idx  = {l1_reg, c_reg, r1_reg};
                    end
                    3'd3: begin
                        cnt_cmd.bump = 1'b1;
                        cnt_cmd.up   = 1'b1;
                        cnt_cmd.idx  = {l1_reg, nc, r1_reg};
                    end
                    3'd4: begin
                        cnt_cmd.bump = has_r2_reg;
                        cnt_cmd.idx  = {c_reg, r1_reg, r2_reg};
                    end
                    3'd5: begin
                        cnt_cmd.bump = has_r2_reg;
                        cnt_cmd.up   = 1'b1;
                        cnt_cmd.idx  = {nc, r1_reg, r2_reg};
                    end
                    default: ;
                endcase
                if (step_reg == ADJ_LAST) begin
                    mem_we     = 1'b1;
                    mem_waddr  = hit_reg[AW-1:0];
                    mem_wdata  = nc;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_pos_next    = (status_reg == STATUS_OK) ? hit_reg : '0;
                    m_counts_next = counts;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[rd_addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            site_count_reg <= SITE_COUNT_RESET;
            clr_reg        <= '0;
            rvalid_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rvalid_reg  <= mem_re;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                site_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        ctx_reg       <= ctx_next;
        u_reg         <= u_next;
        rank_reg      <= rank_next;
        seen_reg      <= seen_next;
        rd_addr_reg   <= rd_addr_next;
        da_reg        <= da_next;
        win_reg       <= win_next;
        hit_reg       <= hit_next;
        l2_reg        <= l2_next;
        l1_reg        <= l1_next;
        c_reg         <= c_next;
        r1_reg        <= r1_next;
        r2_reg        <= r2_next;
        has_l2_reg    <= has_l2_next;
        has_r2_reg    <= has_r2_next;
        step_reg      <= step_next;
        status_reg    <= status_next;
        m_status_reg  <= m_status_next;
        m_pos_reg     <= m_pos_next;
        m_counts_reg  <= m_counts_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_flipped_position = m_pos_reg[SITE_IDX_W-1:0];
    assign m_count_000        = m_counts_reg[0];
    assign m_count_001        = m_counts_reg[1];
    assign m_count_010        = m_counts_reg[2];
    assign m_count_011        = m_counts_reg[3];
    assign m_count_100        = m_counts_reg[4];
    assign m_count_101        = m_counts_reg[5];
    assign m_count_110        = m_counts_reg[6];
    assign m_count_111        = m_counts_reg[7];

`ifndef SYNTHESIS
    a_pos_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != STATUS_OK)) |-> (m_pos_reg == '0))
        else $error("flipped position set on a failed operation");

    a_hit_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADJUST) |-> ((hit_reg >= NW'(1)) && (hit_reg + 1'b1 < n_eff)))
        else $error("flip outside the interior sites");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && rvalid_reg) |-> (da_reg < n_eff))
        else $error("scan ran past the last site");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted beat not dispatched");
`endif

endmodule

// ===== rtl/tcfe_counts.sv =====
module tcfe_counts (
    input  logic                aclk,
    input  logic                aresetn,
    input  tcfe_pkg::count_cmd_t cmd,
    output tcfe_pkg::count_vec_t counts
);
    import tcfe_pkg::*;

    count_vec_t counts_reg;
    count_vec_t counts_next;

    // One shared incrementer/decrementer serves every counter; wraps modulo 2^COUNT_W.
    always_comb begin
        logic [COUNT_W-1:0] sel;
        sel         = counts_reg[cmd.idx];
        counts_next = counts_reg;
        if (cmd.clear) begin
            counts_next = '0;
        end else if (cmd.bump) begin
            counts_next[cmd.idx] = cmd.up ? (sel + 1'b1) : (sel - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg <= '0;
        end else begin
            counts_reg <= counts_next;
        end
    end

    assign counts = counts_reg;

`ifndef SYNTHESIS
    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (counts_reg == '0))
        else $error("counters not zero after clear");
`endif

endmodule
